[hdl/txw_pkg.sv]
// ----------------------------------------------------------------------------
// txw_pkg
// Shared types, constants and arithmetic helpers for the text extent unit:
// Q16.8 saturating lengths, glyph table entries and the per-string state.
// ----------------------------------------------------------------------------
package txw_pkg;

   localparam int GLYPH_ENTRIES = 256;
   localparam int GLYPH_ADDR_W  = $clog2(GLYPH_ENTRIES);
   localparam int FRAC_BITS     = 8;
   localparam int SCALE_FRAC    = 8;
   localparam int ADV_SHIFT     = 6;

   localparam int CODE_W    = 8;
   localparam int ADV_W     = 16;
   localparam int HEIGHT_W  = 10;
   localparam int BEARING_W = 11;
   localparam int SCALE_W   = 16;
   localparam int WRAP_W    = 24;
   localparam int FONT_W    = 8;
   localparam int LEN_W     = 24;
   localparam int LINES_W   = 16;
   localparam int PX_W      = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int PROD_W    = PX_W + SCALE_W + FRAC_BITS;

   localparam logic [LEN_W-1:0]   MAX_LEN   = '1;
   localparam logic [LINES_W-1:0] MAX_LINES = '1;

   localparam logic [CODE_W-1:0] CODE_SPACE   = 8'h20;
   localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_MEASURE = 1'b1;

   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_index_type CSR_SCALE_Q8   = 2'd0;
   localparam csr_index_type CSR_WRAP_WIDTH = 2'd1;
   localparam csr_index_type CSR_FONT_SIZE  = 2'd2;

   typedef logic [LEN_W-1:0] len_type;

   typedef struct packed {
      logic                        present;
      logic [ADV_W-1:0]            advance;
      logic [HEIGHT_W-1:0]         height;
      logic signed [BEARING_W-1:0] bearing;
   } glyph_entry_type;

   typedef struct packed {
      len_type              ww;
      len_type              wa;
      len_type              wd;
      len_type              lx;
      len_type              la;
      len_type              ld;
      len_type              widest;
      len_type              fla;
      logic                 first;
      logic [LINES_W-1:0]   lines;
   } str_state_type;

   localparam str_state_type STR_RESET = '{
      ww: '0, wa: '0, wd: '0, lx: '0, la: '0, ld: '0,
      widest: '0, fla: '0, first: 1'b1, lines: LINES_W'(1)
   };

   // floor(px * scale * 2^FRAC_BITS / 2^SCALE_FRAC), saturated
   function automatic len_type scale_px(input logic [PX_W-1:0] px,
                                        input logic [SCALE_W-1:0] scale);
      logic [PROD_W-1:0] full;
      full = PROD_W'(px) * PROD_W'(scale);
      full = full << FRAC_BITS;
      full = full >> SCALE_FRAC;
      if (full > PROD_W'(MAX_LEN)) return MAX_LEN;
      return full[LEN_W-1:0];
   endfunction

   function automatic len_type sat_add(input len_type a, input len_type b);
      logic [LEN_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[LEN_W] ? MAX_LEN : sum[LEN_W-1:0];
   endfunction

   function automatic len_type max_len(input len_type a, input len_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic str_state_type break_line(input str_state_type st);
      str_state_type r;
      r = st;
      r.widest = max_len(st.widest, st.lx);
      if (st.first) begin
         r.fla   = st.la;
         r.first = 1'b0;
      end
      if (st.lines != MAX_LINES) r.lines = st.lines + LINES_W'(1);
      r.lx = '0;
      r.la = '0;
      r.ld = '0;
      return r;
   endfunction

   function automatic str_state_type end_word(input str_state_type st,
                                              input logic [WRAP_W-1:0] wrap);
      str_state_type r;
      logic [LEN_W:0] sum;
      logic           hit;
      sum = {1'b0, st.lx} + {1'b0, st.ww};
      hit = (wrap != '0) && (st.lx != '0) && (sum > {1'b0, wrap});
      r = st;
      if (hit) begin
         r    = break_line(st);
         r.lx = st.ww;
      end else begin
         r.lx = sum[LEN_W] ? MAX_LEN : sum[LEN_W-1:0];
      end
      r.la = max_len(r.la, st.wa);
      r.ld = max_len(r.ld, st.wd);
      r.ww = '0;
      r.wa = '0;
      r.wd = '0;
      return r;
   endfunction

endpackage

[hdl/txw_req_if.sv]
// ----------------------------------------------------------------------------
// txw_req_if
// Request channel: glyph table loads and characters to measure.
// ----------------------------------------------------------------------------
interface txw_req_if;
   import txw_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [CODE_W-1:0]           char_code;
   logic                        glyph_present;
   logic [ADV_W-1:0]            glyph_advance;
   logic [HEIGHT_W-1:0]         glyph_height;
   logic signed [BEARING_W-1:0] glyph_bearing_y;
   logic                        last;

   modport source (
      output valid, cmd, char_code, glyph_present, glyph_advance,
             glyph_height, glyph_bearing_y, last,
      input  ready
   );

   modport sink (
      input  valid, cmd, char_code, glyph_present, glyph_advance,
             glyph_height, glyph_bearing_y, last,
      output ready
   );

endinterface

[hdl/txw_rsp_if.sv]
// ----------------------------------------------------------------------------
// txw_rsp_if
// Response channel: extent of one measured string.
// ----------------------------------------------------------------------------
interface txw_rsp_if;
   import txw_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEN_W-1:0]   text_width;
   logic [LEN_W-1:0]   text_height;
   logic [LEN_W-1:0]   baseline_offset;
   logic [LINES_W-1:0] line_count;

   modport source (
      output valid, text_width, text_height, baseline_offset, line_count,
      input  ready
   );

   modport sink (
      input  valid, text_width, text_height, baseline_offset, line_count,
      output ready
   );

endinterface

[hdl/text_extent_with_word_wrap_unit.sv]
// ----------------------------------------------------------------------------
// text_extent_with_word_wrap_unit
// Greedy word-wrap text measurer. A glyph table RAM is filled by load
// transfers; measure transfers stream characters and the last one yields
// width, height, baseline and line count of the string.
//
//   channel  dir  handshake          carries
//   req_ch   in   valid/ready        load entry or one character
//   rsp_ch   out  valid/ready        string extent
//   csr_*    in   csr_wr_en          scale_q8, wrap_width, font_size
//
// One transfer per cycle unless stalled; the string state updates combinationally.
// Result path: scale, state, close, spacing, height, output reg.
// Table valid bits all clear on reset; no clearing pass.
// Input stalls only while a finished result waits in the final stage
// behind an untaken output register.
// ----------------------------------------------------------------------------
module text_extent_with_word_wrap_unit (
   input  logic                   clock,
   input  logic                   reset,
   txw_req_if.sink                req_ch,
   txw_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  txw_pkg::csr_index_type csr_index,
   input  txw_pkg::csr_data_type  csr_wdata
);
   import txw_pkg::*;

   // configuration
   logic [SCALE_W-1:0] scale_ff;
   logic [WRAP_W-1:0]  wrap_ff;
   logic [FONT_W-1:0]  font_ff;
   len_type            spacing_ff;

   // pipeline control
   logic adv;
   logic req_xfer;
   logic [GLYPH_ADDR_W-1:0] addr;
   logic in_range;

   // glyph table
   glyph_entry_type         glyph_mem [GLYPH_ENTRIES];
   logic [GLYPH_ENTRIES-1:0] glyph_vld_ff;
   glyph_entry_type         rd_entry_ff;
   logic                    rd_vld_ff;

   // stage 1
   logic s1_valid_ff, s1_meas_ff, s1_space_ff, s1_newline_ff, s1_last_ff;
   logic                         s1_present;
   logic signed [BEARING_W:0]    s1_desc_s;
   logic [PX_W-1:0]              s1_adv_px, s1_asc_px, s1_desc_px;

   // stage 2
   logic    s2_valid_ff, s2_space_ff, s2_newline_ff, s2_last_ff;
   len_type s2_adv_ff, s2_asc_ff, s2_desc_ff;
   str_state_type str_ff, str_in, str_ew;

   // stage 3
   logic          s3_valid_ff, s3_delim_ff;
   str_state_type snap_ff, fin_in;

   // stage 4
   logic               s4_valid_ff;
   len_type            s4_width_ff, s4_fla_ff, s4_ld_ff;
   logic [LINES_W-1:0] s4_lines_ff;

   // stage 5
   logic                       s5_valid_ff;
   len_type                    s5_width_ff, s5_fla_ff;
   logic [LINES_W-1:0]         s5_lines_ff;
   logic [LEN_W:0]             s5_base_ff;
   logic [LEN_W+LINES_W-1:0]   s5_prod_ff;
   logic [LEN_W+LINES_W:0]     s5_height;

   // output register
   logic               rsp_valid_ff;
   len_type            rsp_width_ff, rsp_height_ff, rsp_base_ff;
   logic [LINES_W-1:0] rsp_lines_ff;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_W'(256);
         wrap_ff  <= '0;
         font_ff  <= FONT_W'(48);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCALE_Q8:   scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_WRAP_WIDTH: wrap_ff  <= csr_wdata[WRAP_W-1:0];
            CSR_FONT_SIZE:  font_ff  <= csr_wdata[FONT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      spacing_ff <= scale_px(PX_W'(font_ff), scale_ff);
   end

   // ---------------------------------------------------------- handshake
   assign adv          = !(s5_valid_ff && rsp_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = adv;
   assign req_xfer     = req_ch.valid && adv;
   assign addr         = req_ch.char_code[GLYPH_ADDR_W-1:0];
   assign in_range     = ((CODE_W+1)'(req_ch.char_code) < (CODE_W+1)'(GLYPH_ENTRIES));

   // -------------------------------------------------------- glyph table
   always_ff @(posedge clock) begin
      if (req_xfer && req_ch.cmd == CMD_LOAD && in_range) begin
         glyph_mem[addr] <= '{present: req_ch.glyph_present,
                              advance: req_ch.glyph_advance,
                              height:  req_ch.glyph_height,
                              bearing: req_ch.glyph_bearing_y};
      end
      if (adv) rd_entry_ff <= glyph_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_vld_ff <= '0;
      end else if (req_xfer && req_ch.cmd == CMD_LOAD && in_range) begin
         glyph_vld_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_vld_ff     <= glyph_vld_ff[addr] && in_range;
         s1_meas_ff    <= (req_ch.cmd == CMD_MEASURE);
         s1_space_ff   <= (req_ch.char_code == CODE_SPACE);
         s1_newline_ff <= (req_ch.char_code == CODE_NEWLINE);
         s1_last_ff    <= req_ch.last;
      end
   end

   // ------------------------------------------------ stage 1: scale
   assign s1_present = rd_vld_ff && rd_entry_ff.present;
   assign s1_desc_s  = $signed({2'b00, rd_entry_ff.height})
                     - (BEARING_W+1)'(rd_entry_ff.bearing);

   always_comb begin
      s1_adv_px  = PX_W'(rd_entry_ff.advance >> ADV_SHIFT);
      s1_asc_px  = '0;
      s1_desc_px = '0;
      if (rd_entry_ff.bearing > 0) s1_asc_px = PX_W'(rd_entry_ff.bearing);
      if (s1_desc_s > 0)           s1_desc_px = s1_desc_s[PX_W-1:0];
      if (!s1_present) begin
         s1_adv_px  = '0;
         s1_asc_px  = '0;
         s1_desc_px = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_adv_ff     <= scale_px(s1_adv_px, scale_ff);
         s2_asc_ff     <= scale_px(s1_asc_px, scale_ff);
         s2_desc_ff    <= scale_px(s1_desc_px, scale_ff);
         s2_space_ff   <= s1_space_ff;
         s2_newline_ff <= s1_newline_ff;
         s2_last_ff    <= s1_last_ff;
      end
   end

   // ------------------------------------------- stage 2: string state
   always_comb begin
      str_ew = end_word(str_ff, wrap_ff);
      str_in = str_ff;
      if (s2_newline_ff) begin
         str_in = break_line(str_ew);
      end else if (s2_space_ff) begin
         str_in    = str_ew;
         str_in.lx = sat_add(str_ew.lx, s2_adv_ff);
      end else begin
         str_in.ww = sat_add(str_ff.ww, s2_adv_ff);
         str_in.wa = max_len(str_ff.wa, s2_asc_ff);
         str_in.wd = max_len(str_ff.wd, s2_desc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         str_ff <= STR_RESET;
      end else if (adv && s2_valid_ff) begin
         str_ff <= s2_last_ff ? STR_RESET : str_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff && s2_last_ff) begin
         snap_ff     <= str_in;
         s3_delim_ff <= s2_space_ff || s2_newline_ff;
      end
   end

   // ------------------------------------------- stage 3: close string
   always_comb begin
      fin_in = s3_delim_ff ? snap_ff : end_word(snap_ff, wrap_ff);
      fin_in.widest = max_len(fin_in.widest, fin_in.lx);
      if (fin_in.first) fin_in.fla = fin_in.la;
   end

   always_ff @(posedge clock) begin
      if (adv && s3_valid_ff) begin
         s4_width_ff <= fin_in.widest;
         s4_fla_ff   <= fin_in.fla;
         s4_ld_ff    <= fin_in.ld;
         s4_lines_ff <= fin_in.lines;
      end
   end

   // ------------------------------------------- stage 4: line spacing
   always_ff @(posedge clock) begin
      if (adv && s4_valid_ff) begin
         s5_prod_ff  <= (LEN_W+LINES_W)'(s4_lines_ff - LINES_W'(1))
                      * (LEN_W+LINES_W)'(spacing_ff);
         s5_base_ff  <= {1'b0, s4_fla_ff} + {1'b0, s4_ld_ff};
         s5_width_ff <= s4_width_ff;
         s5_fla_ff   <= s4_fla_ff;
         s5_lines_ff <= s4_lines_ff;
      end
   end

   // ------------------------------------------- stage 5: total height
   assign s5_height = {1'b0, s5_prod_ff} + (LEN_W+LINES_W+1)'(s5_base_ff);

   always_ff @(posedge clock) begin
      if (adv && s5_valid_ff) begin
         rsp_width_ff  <= s5_width_ff;
         rsp_height_ff <= (s5_height > (LEN_W+LINES_W+1)'(MAX_LEN))
                          ? MAX_LEN : s5_height[LEN_W-1:0];
         rsp_base_ff   <= s5_fla_ff;
         rsp_lines_ff  <= s5_lines_ff;
      end
   end

   // -------------------------------------------------- valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= req_xfer;
            s2_valid_ff <= s1_valid_ff && s1_meas_ff;
            s3_valid_ff <= s2_valid_ff && s2_last_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
         end
         if (adv && s5_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.text_width      = rsp_width_ff;
   assign rsp_ch.text_height     = rsp_height_ff;
   assign rsp_ch.baseline_offset = rsp_base_ff;
   assign rsp_ch.line_count      = rsp_lines_ff;

endmodule
